@@ rtl/tssm_pkg.sv @@
package tssm_pkg;

  // Stack heights are 8 bits wide. A push onto a stack at the maximum height is refused.
  typedef logic [7:0] height_t;
  localparam height_t HEIGHT_MAX = 8'd255;

  typedef logic signed [31:0] data_t;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    SEL_BOTTOM = 2'd0,
    SEL_TOP    = 2'd1,
    SEL_MIDDLE = 2'd2
  } sel_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Decision for one request, sent from the planner to the top level
  typedef struct packed {
    logic    wr_en;    // write the push word to the store
    logic    is_read;  // the result takes its data from the store
    logic    upd;      // load height into the selected stack's height
    status_t status;
    height_t height;   // height reported in the result
  } plan_t;

endpackage

@@ rtl/tssm_ram.sv @@
module tssm_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/tssm_plan.sv @@
module tssm_plan #(
  parameter int STORE_DEPTH = 128
) (
  input  logic [1:0]                     req_type,
  input  logic [1:0]                     stack_sel,
  input  tssm_pkg::height_t              bottom_h,
  input  tssm_pkg::height_t              top_h,
  input  tssm_pkg::height_t              mid_h,
  output logic [$clog2(STORE_DEPTH)-1:0] addr,
  output tssm_pkg::plan_t                plan
);

  localparam int AW = $clog2(STORE_DEPTH);
  // The width must hold the store depth plus a height of up to 256.
  localparam int CW = ((AW > 9) ? AW : 9) + 2;
  localparam logic [CW-1:0] D_C = CW'(STORE_DEPTH);
  localparam logic [CW-1:0] M_C = CW'(STORE_DEPTH / 2);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  tssm_pkg::height_t h;
  logic [CW-1:0]     tgt;
  logic [CW-1:0]     half;
  logic [CW-1:0]     slot;
  logic              slot_ok;
  logic              in_range;
  logic              held;
  logic              sel_ok;

  // Select the height of the chosen stack, then compute the slot for the target height.
  always_comb begin
    unique case (stack_sel)
      tssm_pkg::SEL_BOTTOM: h = bottom_h;
      tssm_pkg::SEL_TOP:    h = top_h;
      tssm_pkg::SEL_MIDDLE: h = mid_h;
      default:              h = '0;
    endcase
    sel_ok = (stack_sel == tssm_pkg::SEL_BOTTOM) || (stack_sel == tssm_pkg::SEL_TOP) ||
             (stack_sel == tssm_pkg::SEL_MIDDLE);

    tgt  = (req_type == tssm_pkg::REQ_PUSH) ? CW'(h) + ONE_C : CW'(h);
    half = (tgt + ONE_C) >> 1;
    slot    = '0;
    slot_ok = 1'b0;
    unique case (stack_sel)
      tssm_pkg::SEL_BOTTOM: begin
        slot    = tgt;
        slot_ok = 1'b1;
      end
      tssm_pkg::SEL_TOP: begin
        slot    = D_C - tgt;
        slot_ok = tgt < D_C;
      end
      tssm_pkg::SEL_MIDDLE: begin
        // Odd heights sit below the midpoint and even heights sit above it.
        if (tgt[0]) begin
          slot    = M_C - half;
          slot_ok = half < M_C;
        end else begin
          slot    = M_C + (tgt >> 1);
          slot_ok = 1'b1;
        end
      end
      default: begin
        slot    = '0;
        slot_ok = 1'b0;
      end
    endcase
    in_range = slot_ok && (slot >= ONE_C) && (slot <= D_C - ONE_C);
  end

  // Check whether another stack already holds the slot.
  always_comb begin
    held = 1'b0;
    if ((stack_sel != tssm_pkg::SEL_BOTTOM) && (slot >= ONE_C) &&
        (slot <= CW'(bottom_h))) begin
      held = 1'b1;
    end
    if ((stack_sel != tssm_pkg::SEL_TOP) && (top_h != '0) &&
        (slot + CW'(top_h) >= D_C) && (slot < D_C)) begin
      held = 1'b1;
    end
    if (stack_sel != tssm_pkg::SEL_MIDDLE) begin
      if ((slot < M_C) && (slot + ((CW'(mid_h) + ONE_C) >> 1) >= M_C)) begin
        held = 1'b1;
      end
      if ((slot > M_C) && (slot <= M_C + (CW'(mid_h) >> 1))) begin
        held = 1'b1;
      end
    end
  end

  always_comb begin
    plan.wr_en   = 1'b0;
    plan.is_read = 1'b0;
    plan.upd     = 1'b0;
    plan.status  = tssm_pkg::ST_OK;
    plan.height  = h;
    if (sel_ok) begin
      unique case (req_type)
        tssm_pkg::REQ_PUSH: begin
          if ((h == tssm_pkg::HEIGHT_MAX) || !in_range || (slot == M_C) || held) begin
            plan.status = tssm_pkg::ST_FULL;
          end else begin
            plan.wr_en  = 1'b1;
            plan.upd    = 1'b1;
            plan.height = h + 8'd1;
          end
        end
        tssm_pkg::REQ_POP, tssm_pkg::REQ_PEEK: begin
          if ((h == '0) || !in_range) begin
            plan.status = tssm_pkg::ST_EMPTY;
          end else begin
            plan.is_read = 1'b1;
            if (req_type == tssm_pkg::REQ_POP) begin
              plan.upd    = 1'b1;
              plan.height = h - 8'd1;
            end
          end
        end
        default: ;
      endcase
    end else begin
      plan.height = '0;
    end
  end

  assign addr = slot[AW-1:0];

endmodule

@@ rtl/triple_stack_shared_memory.sv @@
// Channel  Ports                                        Direction  Moves
// in       in_valid / in_stall, in_req_type,            input      one request word
//          in_stack_sel, in_push_value
// out      out_valid / out_stall, out_data_out,         output     one result word
//          out_status, out_height_now
//
// Throughput is one request per cycle while out_stall does not hold the output register.
// An accepted request is registered in stage 1. The planner and the store access finish at
// the accepting edge; stage 1 then carries the read data into the output register.
// Heights update at the edge that accepts a request, so the next request sees them at once.
// Reset is synchronous and active low. It clears the three heights and both valid flags.
// The store is not cleared, because no entry is read before it is written.
// When out_stall holds the output register, the pending stage waits and in_stall goes high.
module triple_stack_shared_memory #(
  parameter int STORE_DEPTH = 128,
  parameter int WORD_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [1:0]         in_stack_sel,
  input  logic signed [31:0] in_push_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_data_out,
  output logic [1:0]         out_status,
  output logic [7:0]         out_height_now
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = ((AW > 9) ? AW : 9) + 2;

  // Stack heights. These are the only control state besides the pipeline valid flags.
  tssm_pkg::height_t bottom_h_r, bottom_h_nxt;
  tssm_pkg::height_t top_h_r, top_h_nxt;
  tssm_pkg::height_t mid_h_r, mid_h_nxt;

  // Stage 1 holds an accepted request. If it is a read, its data arrives from the store here.
  logic              s1_v_r, s1_v_nxt;
  logic              s1_read_r, s1_read_nxt;
  tssm_pkg::status_t s1_status_r, s1_status_nxt;
  tssm_pkg::height_t s1_height_r, s1_height_nxt;
  logic [AW-1:0]     s1_addr_r, s1_addr_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  tssm_pkg::data_t   out_data_r, out_data_nxt;
  tssm_pkg::status_t out_status_r, out_status_nxt;
  tssm_pkg::height_t out_height_r, out_height_nxt;

  tssm_pkg::plan_t   plan;
  logic [AW-1:0]     plan_addr;
  logic [AW-1:0]     rd_addr;
  logic [WORD_WIDTH-1:0] rd_data;
  logic              accept_in;
  logic              move;

  tssm_plan #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_plan (
    .req_type (in_req_type),
    .stack_sel(in_stack_sel),
    .bottom_h (bottom_h_r),
    .top_h    (top_h_r),
    .mid_h    (mid_h_r),
    .addr     (plan_addr),
    .plan     (plan)
  );

  // Re-read the held address while stage 1 waits, so its read data stays valid.
  // No push can be accepted during that time.
  assign rd_addr = accept_in ? plan_addr : s1_addr_r;

  tssm_ram #(
    .DEPTH(STORE_DEPTH),
    .WIDTH(WORD_WIDTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (accept_in && plan.wr_en),
    .wr_addr(plan_addr),
    .wr_data(WORD_WIDTH'(in_push_value)),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Handshake
  assign move      = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_v_r && !move;
  assign accept_in = in_valid && !in_stall;

  // Height update at accept
  always_comb begin
    bottom_h_nxt = bottom_h_r;
    top_h_nxt    = top_h_r;
    mid_h_nxt    = mid_h_r;
    if (accept_in && plan.upd) begin
      unique case (in_stack_sel)
        tssm_pkg::SEL_BOTTOM: bottom_h_nxt = plan.height;
        tssm_pkg::SEL_TOP:    top_h_nxt    = plan.height;
        tssm_pkg::SEL_MIDDLE: mid_h_nxt    = plan.height;
        default: ;
      endcase
    end
  end

  // Stage 1 next
  always_comb begin
    s1_v_nxt      = accept_in || (s1_v_r && !move);
    s1_read_nxt   = s1_read_r;
    s1_status_nxt = s1_status_r;
    s1_height_nxt = s1_height_r;
    s1_addr_nxt   = s1_addr_r;
    if (accept_in) begin
      s1_read_nxt   = plan.is_read;
      s1_status_nxt = plan.status;
      s1_height_nxt = plan.height;
      s1_addr_nxt   = plan_addr;
    end
  end

  // Output next. Store words are sign-extended, or cut down, to 32 bits.
  always_comb begin
    out_valid_nxt  = move || (out_valid_r && out_stall);
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_height_nxt = out_height_r;
    if (move) begin
      out_data_nxt   = s1_read_r ? tssm_pkg::data_t'(32'($signed(rd_data))) : '0;
      out_status_nxt = s1_status_r;
      out_height_nxt = s1_height_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bottom_h_r  <= '0;
      top_h_r     <= '0;
      mid_h_r     <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bottom_h_r  <= bottom_h_nxt;
      top_h_r     <= top_h_nxt;
      mid_h_r     <= mid_h_nxt;
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_read_r    <= s1_read_nxt;
    s1_status_r  <= s1_status_nxt;
    s1_height_r  <= s1_height_nxt;
    s1_addr_r    <= s1_addr_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_height_r <= out_height_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_status     = out_status_r;
  assign out_height_now = out_height_r;

  // The bottom and top stacks never meet.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(bottom_h_r) + CW'(top_h_r)) < CW'(STORE_DEPTH))
    else $error("bottom and top stacks overlap");

  // A refused or empty request leaves every height unchanged.
  a_err_keeps_heights: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_in && (plan.status != tssm_pkg::ST_OK)) |=>
      ($stable(bottom_h_r) && $stable(top_h_r) && $stable(mid_h_r)))
    else $error("height changed on a refused request");

  // A waiting stage 1 keeps its address, so the re-read returns the same entry.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !move) |=> (s1_v_r && $stable(s1_addr_r) && $stable(s1_read_r)))
    else $error("stage 1 lost while waiting");

endmodule
